// ===== rtl/xta_pkg.sv =====
// Shared types and constants for the XML tag attribute checker.
// Used by xta_front, xta_back and the top level under rtl; depends on nothing.
package xta_pkg;

    // Result error codes; the first one found wins
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_LEAD_BLANK = 4'd1;
    localparam logic [3:0] ERR_EMPTY_NAME = 4'd2;
    localparam logic [3:0] ERR_BAD_FIRST  = 4'd3;
    localparam logic [3:0] ERR_BAD_CHAR   = 4'd4;
    localparam logic [3:0] ERR_PRE_QUOTE  = 4'd5;
    localparam logic [3:0] ERR_LT_VALUE   = 4'd6;
    localparam logic [3:0] ERR_ENTITY     = 4'd7;
    localparam logic [3:0] ERR_DUPLICATE  = 4'd8;
    localparam logic [3:0] ERR_UNTERM     = 4'd9;
    localparam logic [3:0] ERR_CAPACITY   = 4'd10;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    localparam int NUM_ENT = 5;

    typedef enum logic [2:0] {
        PH_START,
        PH_TAGNAME,
        PH_ATTRNAME,
        PH_BEFOREQ,
        PH_VALUE
    } phase_t;

    // Character classes worked out in the front end
    typedef struct packed {
        logic blank;
        logic first_ok;
        logic later_ok;
        logic is_eq;
        logic is_dq;
        logic is_sq;
        logic is_lt;
        logic is_amp;
    } char_class_t;

    // One queued beat
    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        char_class_t cls;
    } beat_t;

    // Queue handshake between front and back
    typedef struct packed {
        logic  valid;
        beat_t beat;
    } queue_out_t;

    // Expected byte of entity k (lt; gt; amp; apos; quot;) at position p
    function automatic logic [7:0] ent_char(input logic [2:0] k, input logic [2:0] p);
        logic [7:0] r;
        r = 8'h00;
        case (k)
            3'd0: case (p) 3'd0: r = "l"; 3'd1: r = "t"; 3'd2: r = ";"; default: r = 8'h00; endcase
            3'd1: case (p) 3'd0: r = "g"; 3'd1: r = "t"; 3'd2: r = ";"; default: r = 8'h00; endcase
            3'd2: case (p) 3'd0: r = "a"; 3'd1: r = "m"; 3'd2: r = "p"; 3'd3: r = ";";
                           default: r = 8'h00; endcase
            3'd3: case (p) 3'd0: r = "a"; 3'd1: r = "p"; 3'd2: r = "o"; 3'd3: r = "s";
                           3'd4: r = ";"; default: r = 8'h00; endcase
            3'd4: case (p) 3'd0: r = "q"; 3'd1: r = "u"; 3'd2: r = "o"; 3'd3: r = "t";
                           3'd4: r = ";"; default: r = 8'h00; endcase
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] ent_len(input logic [2:0] k);
        logic [2:0] r;
        case (k)
            3'd0: r = 3'd3;
            3'd1: r = 3'd3;
            3'd2: r = 3'd4;
            default: r = 3'd5;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/xta_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module xta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read; read data is registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/xta_front.sv =====
// Front end: accepts tag bytes, classifies them and queues them for the parser.
// Depends on xta_pkg.
module xta_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [7:0]          tag_char,
    input  logic                last_char,
    output xta_pkg::queue_out_t q_out,
    input  logic                q_pop
);
    import xta_pkg::*;

    beat_t       slot_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  count_reg, count_next;
    char_class_t cls;
    logic        alnum;
    logic        push;

    // Classify the incoming byte
    always_comb
    begin
        alnum = (tag_char >= "0" && tag_char <= "9") || (tag_char >= "a" && tag_char <= "z")
             || (tag_char >= "A" && tag_char <= "Z");
        cls.blank    = (tag_char == CH_SPACE) || (tag_char == CH_TAB);
        cls.first_ok = alnum || (tag_char == CH_UNDER);
        cls.later_ok = alnum || (tag_char == CH_UNDER) || (tag_char == CH_DOT)
                    || (tag_char == CH_DASH);
        cls.is_eq    = tag_char == CH_EQ;
        cls.is_dq    = tag_char == CH_DQUOTE;
        cls.is_sq    = tag_char == CH_SQUOTE;
        cls.is_lt    = tag_char == CH_LT;
        cls.is_amp   = tag_char == CH_AMP;
    end

    assign item_ready = count_reg != 2'd2;
    assign push       = item_valid && item_ready;

    // Advance queue pointers
    always_comb
    begin
        wptr_next  = push  ? ~wptr_reg : wptr_reg;
        rptr_next  = q_pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Hold queued beats
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= '{ch: tag_char, last: last_char, cls: cls};
        end
    end

    assign q_out.valid = count_reg != 2'd0;
    assign q_out.beat  = slot_reg[rptr_reg];
endmodule

// ===== rtl/xta_back.sv =====
// Back end: tag parser, incremental duplicate-name matching and result register.
// Depends on xta_pkg and xta_ram.
module xta_back #(
    parameter int MAX_ATTRS    = 8,
    parameter int MAX_NAME_LEN = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  xta_pkg::queue_out_t q_out,
    output logic                q_pop,
    output logic                result_valid,
    input  logic                result_ready,
    output logic                tag_ok,
    output logic [3:0]          error_code,
    output logic [3:0]          attribute_count
);
    import xta_pkg::*;

    localparam int NLW = $clog2(MAX_NAME_LEN + 2);
    localparam int AW  = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
    localparam int CW  = $clog2(MAX_ATTRS + 1);
    localparam int SW  = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;

    phase_t              phase_reg, phase_next;
    logic [3:0]          ferr_reg, ferr_next;
    logic [NLW-1:0]      nlen_reg, nlen_next;
    logic                blank_after_reg, blank_after_next;
    logic                pending_reg, pending_next;
    logic                qdbl_reg, qdbl_next;
    logic [NUM_ENT-1:0]  ecand_reg, ecand_next;
    logic [2:0]          epos_reg, epos_next;
    logic [CW-1:0]       acnt_reg, acnt_next;
    logic [3:0]          nfault_reg, nfault_next;
    logic [3:0]          vfault_reg, vfault_next;
    logic [MAX_ATTRS-1:0] mism_reg, mism_next;
    logic                dup_reg, dup_next;
    logic [NLW-1:0]      slen_reg [MAX_ATTRS];
    logic                slen_we;

    logic                out_valid_reg, out_valid_next;
    logic                out_ok_reg;
    logic [3:0]          out_err_reg;
    logic [3:0]          out_cnt_reg;
    logic [CW+3:0]       acnt_ext;
    logic                emit;

    logic                name_we;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr;
    logic [7:0]          rd_data [MAX_ATTRS];
    logic [MAX_ATTRS-1:0] hit;

    logic [7:0]          c;
    char_class_t         cl;
    logic [3:0]          vf_eff;
    logic [NUM_ENT-1:0]  keep;
    logic                done;
    logic [2:0]          ep;

    assign c  = q_out.beat.ch;
    assign cl = q_out.beat.cls;

    // Pop a beat unless it would end a tag while the result slot is still full
    assign q_pop = q_out.valid && (!q_out.beat.last || !out_valid_reg || result_ready);

    // Name stores: one RAM per attribute slot, read ahead at the next name position
    assign waddr = nlen_reg[AW-1:0];
    assign raddr = (nlen_next < NLW'(MAX_NAME_LEN)) ? nlen_next[AW-1:0] : '0;

    for (genvar j = 0; j < MAX_ATTRS; j++)
    begin : g_slot
        xta_ram #(.WIDTH(8), .DEPTH(MAX_NAME_LEN), .AW(AW)) u_name_ram (
            .clk   (clk),
            .we    (name_we && (acnt_reg == CW'(j))),
            .waddr (waddr),
            .wdata (c),
            .raddr (raddr),
            .rdata (rd_data[j])
        );
        assign hit[j] = (CW'(j) < acnt_reg) && !mism_reg[j] && (slen_reg[j] == nlen_reg);
    end

    // Parse one beat
    always_comb
    begin
        phase_next       = phase_reg;
        ferr_next        = ferr_reg;
        nlen_next        = nlen_reg;
        blank_after_next = blank_after_reg;
        pending_next     = pending_reg;
        qdbl_next        = qdbl_reg;
        ecand_next       = ecand_reg;
        epos_next        = epos_reg;
        acnt_next        = acnt_reg;
        nfault_next      = nfault_reg;
        vfault_next      = vfault_reg;
        mism_next        = mism_reg;
        dup_next         = dup_reg;
        slen_we          = 1'b0;
        name_we          = 1'b0;
        emit             = 1'b0;
        vf_eff           = vfault_reg;
        keep             = '0;
        done             = 1'b0;
        ep               = epos_reg - 3'd1;

        if (q_pop && ferr_reg == ERR_NONE)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (cl.blank)
                        ferr_next = ERR_LEAD_BLANK;
                    else if (!cl.first_ok)
                        ferr_next = ERR_BAD_FIRST;
                    else
                        phase_next = PH_TAGNAME;
                end
                PH_TAGNAME:
                begin
                    if (cl.blank)
                    begin
                        phase_next       = PH_ATTRNAME;
                        nlen_next        = '0;
                        blank_after_next = 1'b0;
                        pending_next     = 1'b0;
                        nfault_next      = ERR_NONE;
                        mism_next        = '0;
                    end
                    else if (!cl.later_ok)
                        ferr_next = ERR_BAD_CHAR;
                end
                PH_ATTRNAME:
                begin
                    if (cl.is_eq)
                    begin
                        if (nlen_reg == '0)
                            ferr_next = ERR_EMPTY_NAME;
                        else if (nfault_reg != ERR_NONE)
                            ferr_next = nfault_reg;
                        else if (nlen_reg > NLW'(MAX_NAME_LEN) || acnt_reg >= CW'(MAX_ATTRS))
                            ferr_next = ERR_CAPACITY;
                        else
                        begin
                            dup_next     = |hit;
                            phase_next   = PH_BEFOREQ;
                            pending_next = 1'b0;
                        end
                    end
                    else
                    begin
                        pending_next = 1'b1;
                        if (cl.blank)
                        begin
                            if (nlen_reg != '0)
                                blank_after_next = 1'b1;
                        end
                        else
                        begin
                            if (nlen_reg == '0)
                            begin
                                if (!cl.first_ok)
                                    nfault_next = ERR_BAD_FIRST;
                            end
                            else if ((blank_after_reg || !cl.later_ok)
                                     && nfault_reg == ERR_NONE)
                                nfault_next = ERR_BAD_CHAR;
                            if (nlen_reg < NLW'(MAX_NAME_LEN))
                            begin
                                name_we = acnt_reg < CW'(MAX_ATTRS);
                                for (int j = 0; j < MAX_ATTRS; j++)
                                begin
                                    if (rd_data[j] != c)
                                        mism_next[j] = 1'b1;
                                end
                            end
                            if (nlen_reg <= NLW'(MAX_NAME_LEN))
                                nlen_next = nlen_reg + NLW'(1);
                        end
                    end
                end
                PH_BEFOREQ:
                begin
                    if (cl.is_dq || cl.is_sq)
                    begin
                        if (pending_reg)
                            ferr_next = ERR_PRE_QUOTE;
                        else
                        begin
                            qdbl_next   = cl.is_dq;
                            vfault_next = ERR_NONE;
                            epos_next   = '0;
                            ecand_next  = '0;
                            phase_next  = PH_VALUE;
                        end
                    end
                    else if (!cl.blank)
                        pending_next = 1'b1;
                end
                PH_VALUE:
                begin
                    if (qdbl_reg ? cl.is_dq : cl.is_sq)
                    begin
                        if (epos_reg != '0 && vfault_reg == ERR_NONE)
                            vf_eff = ERR_ENTITY;
                        vfault_next = vf_eff;
                        epos_next   = '0;
                        ecand_next  = '0;
                        if (vf_eff != ERR_NONE)
                            ferr_next = vf_eff;
                        else if (dup_reg)
                            ferr_next = ERR_DUPLICATE;
                        else
                        begin
                            slen_we          = 1'b1;
                            acnt_next        = acnt_reg + CW'(1);
                            phase_next       = PH_ATTRNAME;
                            nlen_next        = '0;
                            blank_after_next = 1'b0;
                            pending_next     = 1'b0;
                            nfault_next      = ERR_NONE;
                            mism_next        = '0;
                        end
                    end
                    else if (vfault_reg != ERR_NONE)
                    begin
                        vfault_next = vfault_reg;
                    end
                    else if (epos_reg != '0)
                    begin
                        // Narrow the entity candidates by this byte
                        for (int k = 0; k < NUM_ENT; k++)
                        begin
                            if (ecand_reg[k] && ep < ent_len(3'(k)) && ent_char(3'(k), ep) == c)
                            begin
                                keep[k] = 1'b1;
                                if (c == CH_SEMI)
                                    done = 1'b1;
                            end
                        end
                        if (keep == '0)
                        begin
                            vfault_next = ERR_ENTITY;
                            epos_next   = '0;
                            ecand_next  = '0;
                        end
                        else if (done)
                        begin
                            epos_next  = '0;
                            ecand_next = '0;
                        end
                        else
                        begin
                            epos_next  = epos_reg + 3'd1;
                            ecand_next = keep;
                        end
                    end
                    else if (cl.is_lt)
                        vfault_next = ERR_LT_VALUE;
                    else if (cl.is_amp)
                    begin
                        ecand_next = '1;
                        epos_next  = 3'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end

        // End of tag: final checks, then return to the start state
        if (q_pop && q_out.beat.last)
        begin
            emit = 1'b1;
            if (ferr_next == ERR_NONE && (phase_next == PH_BEFOREQ || phase_next == PH_VALUE
                || (phase_next == PH_ATTRNAME && nlen_next != '0)))
                ferr_next = ERR_UNTERM;
        end
    end

    assign acnt_ext = {4'b0, acnt_next};
    assign out_valid_next = emit ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            ferr_reg        <= ERR_NONE;
            nlen_reg        <= '0;
            blank_after_reg <= 1'b0;
            pending_reg     <= 1'b0;
            qdbl_reg        <= 1'b0;
            ecand_reg       <= '0;
            epos_reg        <= '0;
            acnt_reg        <= '0;
            nfault_reg      <= ERR_NONE;
            vfault_reg      <= ERR_NONE;
            mism_reg        <= '0;
            dup_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (emit)
        begin
            phase_reg       <= PH_START;
            ferr_reg        <= ERR_NONE;
            nlen_reg        <= '0;
            blank_after_reg <= 1'b0;
            pending_reg     <= 1'b0;
            qdbl_reg        <= 1'b0;
            ecand_reg       <= '0;
            epos_reg        <= '0;
            acnt_reg        <= '0;
            nfault_reg      <= ERR_NONE;
            vfault_reg      <= ERR_NONE;
            mism_reg        <= '0;
            dup_reg         <= 1'b0;
            out_valid_reg   <= out_valid_next;
        end
        else
        begin
            phase_reg       <= phase_next;
            ferr_reg        <= ferr_next;
            nlen_reg        <= nlen_next;
            blank_after_reg <= blank_after_next;
            pending_reg     <= pending_next;
            qdbl_reg        <= qdbl_next;
            ecand_reg       <= ecand_next;
            epos_reg        <= epos_next;
            acnt_reg        <= acnt_next;
            nfault_reg      <= nfault_next;
            vfault_reg      <= vfault_next;
            mism_reg        <= mism_next;
            dup_reg         <= dup_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Hold the result payload and the stored name lengths
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_ok_reg  <= ferr_next == ERR_NONE;
            out_err_reg <= ferr_next;
            out_cnt_reg <= (acnt_ext > (CW+4)'(15)) ? 4'd15 : acnt_ext[3:0];
        end
        if (slen_we)
        begin
            slen_reg[acnt_reg[SW-1:0]] <= nlen_reg;
        end
    end

    assign result_valid    = out_valid_reg;
    assign tag_ok          = out_ok_reg;
    assign error_code      = out_err_reg;
    assign attribute_count = out_cnt_reg;
endmodule

// ===== rtl/xml_tag_attribute_checker.sv =====
// Top level of the XML tag attribute checker: front end, queue and parser.
// Depends on xta_pkg, xta_front, xta_back and xta_ram.
//
// Takes the text of one XML tag a byte per beat, last_char marking the final
// byte, and returns one result per tag: tag_ok, the first error_code found and
// the attribute_count. The block sustains one byte per clock while results are
// accepted: bytes are classified in the front end, pass through a two-entry queue
// and are parsed in the back end. Duplicate names are found by comparing each
// name byte as it arrives against every stored name at the same position; each
// of the MAX_ATTRS name slots is a RAM read one position ahead. The result sits
// in an output register, so the next tag streams in while it waits. No clearing
// pass is needed after reset.
module xml_tag_attribute_checker #(
    parameter int MAX_ATTRS    = 8,
    parameter int MAX_NAME_LEN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] tag_char,
    input  logic       last_char,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       tag_ok,
    output logic [3:0] error_code,
    output logic [3:0] attribute_count
);
    import xta_pkg::*;

    queue_out_t q_out;
    logic       q_pop;

    xta_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .tag_char   (tag_char),
        .last_char  (last_char),
        .q_out      (q_out),
        .q_pop      (q_pop)
    );

    xta_back #(.MAX_ATTRS(MAX_ATTRS), .MAX_NAME_LEN(MAX_NAME_LEN)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_out           (q_out),
        .q_pop           (q_pop),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .tag_ok          (tag_ok),
        .error_code      (error_code),
        .attribute_count (attribute_count)
    );

    // Result payload agrees with itself and stays in range
    a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (tag_ok == (error_code == ERR_NONE)))
        else $error("tag_ok disagrees with error_code");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (error_code <= ERR_CAPACITY))
        else $error("error_code out of range");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({28'd0, attribute_count} <= MAX_ATTRS))
        else $error("attribute_count above slot count");
endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for xml_tag_attribute_checker: streams tag text
// byte by byte and compares every result with an internal tag parser model.
// Depends on xta_pkg and the RTL under rtl.
`timescale 1ns / 100ps

module tb_top;
    import xta_pkg::*;

    localparam int ATTR_CAP  = 8;
    localparam int NAME_CAP  = 32;
    localparam int LIMIT_CYC = 1000000;

    typedef struct {
        logic       ok;
        logic [3:0] code;
        logic [3:0] count;
    } tag_result_t;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    logic [7:0] tag_char;
    logic       last_char;
    logic       result_valid;
    logic       result_ready;
    logic       tag_ok;
    logic [3:0] error_code;
    logic [3:0] attribute_count;

    tag_result_t pending_results[$];
    int mismatches;
    int cycles;
    int lost_results;
    bit stall_on;

    // parser model state
    phase_t     m_phase;
    logic [3:0] m_err;
    int         m_len;
    bit         m_blank_after;
    bit         m_pending_text;
    bit         m_dq;
    logic [4:0] m_cand;
    int         m_epos;
    int         m_count;
    logic [7:0] m_names[ATTR_CAP][NAME_CAP];
    int         m_lens[ATTR_CAP];
    bit         m_dup;
    logic [3:0] m_name_fault;
    logic [3:0] m_value_fault;

    xml_tag_attribute_checker u_dut (
        .clk(clk), .rst_n(rst_n), .item_valid(item_valid), .item_ready(item_ready),
        .tag_char(tag_char), .last_char(last_char), .result_valid(result_valid),
        .result_ready(result_ready), .tag_ok(tag_ok), .error_code(error_code),
        .attribute_count(attribute_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit first_ok(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
               (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic bit later_ok(logic [7:0] c);
        return first_ok(c) || c == CH_DOT || c == CH_DASH;
    endfunction

    function automatic logic [7:0] entity_byte(int k, int p);
        string s;
        case (k)
            0: s = "lt;";
            1: s = "gt;";
            2: s = "amp;";
            3: s = "apos;";
            default: s = "quot;";
        endcase
        return (p < s.len()) ? s[p] : 8'h00;
    endfunction

    task automatic flag(logic [3:0] code);
        if (m_err == ERR_NONE)
            m_err = code;
    endtask

    task automatic start_name();
        m_len = 0;
        m_blank_after = 0;
        m_pending_text = 0;
        m_name_fault = ERR_NONE;
    endtask

    task automatic clear_parser();
        m_phase = PH_START;
        m_err = ERR_NONE;
        m_dq = 0;
        m_cand = '0;
        m_epos = 0;
        m_count = 0;
        m_dup = 0;
        m_value_fault = ERR_NONE;
        start_name();
    endtask

    task automatic parse_name_byte(logic [7:0] c);
        m_pending_text = 1;
        if (is_blank(c))
        begin
            if (m_len > 0)
                m_blank_after = 1;
            return;
        end
        if (m_len == 0)
        begin
            if (!first_ok(c))
                m_name_fault = ERR_BAD_FIRST;
        end
        else if ((m_blank_after || !later_ok(c)) && m_name_fault == ERR_NONE)
            m_name_fault = ERR_BAD_CHAR;
        if (m_len < NAME_CAP && m_count < ATTR_CAP)
            m_names[m_count][m_len] = c;
        if (m_len <= NAME_CAP)
            m_len++;
    endtask

    task automatic parse_equals();
        bit same;
        if (m_len == 0)
        begin
            flag(ERR_EMPTY_NAME);
            return;
        end
        if (m_name_fault != ERR_NONE)
        begin
            flag(m_name_fault);
            return;
        end
        if (m_len > NAME_CAP || m_count >= ATTR_CAP)
        begin
            flag(ERR_CAPACITY);
            return;
        end
        m_dup = 0;
        for (int j = 0; j < m_count; j++)
        begin
            same = (m_lens[j] == m_len);
            for (int p = 0; same && p < m_len; p++)
                if (m_names[j][p] != m_names[m_count][p])
                    same = 0;
            if (same)
                m_dup = 1;
        end
        m_phase = PH_BEFOREQ;
        m_pending_text = 0;
    endtask

    task automatic parse_value_byte(logic [7:0] c);
        logic [4:0] keep;
        bit done;
        keep = '0;
        done = 0;
        if (c == (m_dq ? CH_DQUOTE : CH_SQUOTE))
        begin
            if (m_epos != 0 && m_value_fault == ERR_NONE)
                m_value_fault = ERR_ENTITY;
            m_epos = 0;
            m_cand = '0;
            if (m_value_fault != ERR_NONE)
            begin
                flag(m_value_fault);
                return;
            end
            if (m_dup)
            begin
                flag(ERR_DUPLICATE);
                return;
            end
            m_lens[m_count] = m_len;
            m_count++;
            m_phase = PH_ATTRNAME;
            start_name();
            return;
        end
        if (m_value_fault != ERR_NONE)
            return;
        if (m_epos != 0)
        begin
            for (int k = 0; k < 5; k++)
                if (m_cand[k] && entity_byte(k, m_epos - 1) == c)
                begin
                    keep[k] = 1'b1;
                    if (c == CH_SEMI)
                        done = 1;
                end
            if (keep == '0)
            begin
                m_value_fault = ERR_ENTITY;
                m_epos = 0;
            end
            else if (done)
            begin
                m_epos = 0;
                keep = '0;
            end
            else
                m_epos++;
            m_cand = keep;
            return;
        end
        if (c == CH_LT)
            m_value_fault = ERR_LT_VALUE;
        else if (c == CH_AMP)
        begin
            m_cand = 5'h1F;
            m_epos = 1;
        end
    endtask

    task automatic parse_byte(logic [7:0] c);
        case (m_phase)
            PH_START:
                if (is_blank(c))
                    flag(ERR_LEAD_BLANK);
                else if (!first_ok(c))
                    flag(ERR_BAD_FIRST);
                else
                    m_phase = PH_TAGNAME;
            PH_TAGNAME:
                if (is_blank(c))
                begin
                    m_phase = PH_ATTRNAME;
                    start_name();
                end
                else if (!later_ok(c))
                    flag(ERR_BAD_CHAR);
            PH_ATTRNAME:
                if (c == CH_EQ)
                    parse_equals();
                else
                    parse_name_byte(c);
            PH_BEFOREQ:
                if (c == CH_DQUOTE || c == CH_SQUOTE)
                begin
                    if (m_pending_text)
                        flag(ERR_PRE_QUOTE);
                    else
                    begin
                        m_dq = (c == CH_DQUOTE);
                        m_value_fault = ERR_NONE;
                        m_epos = 0;
                        m_cand = '0;
                        m_phase = PH_VALUE;
                    end
                end
                else if (!is_blank(c))
                    m_pending_text = 1;
            default:
                parse_value_byte(c);
        endcase
    endtask

    // Advance the model by one byte; queue a result on the final byte
    task automatic model_byte(logic [7:0] c, logic fin);
        tag_result_t r;
        if (m_err == ERR_NONE)
            parse_byte(c);
        if (!fin)
            return;
        if (m_err == ERR_NONE)
        begin
            if (m_phase == PH_BEFOREQ || m_phase == PH_VALUE)
                flag(ERR_UNTERM);
            else if (m_phase == PH_ATTRNAME && m_len > 0)
                flag(ERR_UNTERM);
        end
        r.ok = (m_err == ERR_NONE);
        r.code = m_err;
        r.count = (m_count > 15) ? 4'd15 : 4'(m_count);
        pending_results = {pending_results, r};
        clear_parser();
    endtask

    // Send one beat, with an occasional random gap first
    task automatic send_byte(logic [7:0] c, logic fin);
        if ($urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid <= 1'b1;
        tag_char <= c;
        last_char <= fin;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        model_byte(c, fin);
    endtask

    task automatic send_tag(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic idle_sender();
        item_valid <= 1'b0;
    endtask

    // Receiver stall pattern: stretches of heavy stall, then none
    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                stall_on = !stall_on;
            result_ready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
        end
    end

    // Check each result beat against the oldest expected result
    always @(posedge clk)
    begin
        tag_result_t e;
        cycles <= cycles + 1;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                lost_results <= lost_results + 1;
                if (mismatches < 10)
                    $display("unexpected result ok=%0d code=%0d cnt=%0d",
                             tag_ok, error_code, attribute_count);
                mismatches = mismatches + 1;
            end
            else
            begin
                e = pending_results.pop_front();
                if (tag_ok !== e.ok || error_code !== e.code || attribute_count !== e.count)
                begin
                    if (mismatches < 10)
                        $display("mismatch: exp ok=%0d code=%0d cnt=%0d, got %0d %0d %0d",
                                 e.ok, e.code, e.count, tag_ok, error_code,
                                 attribute_count);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    initial
    begin
        wait (cycles >= LIMIT_CYC);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [7:0] rand_name_char(bit first);
        string pool;
        pool = first ? "abcXYZ_09" : "abcXYZ_09.-";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic string rand_name(int maxlen);
        string s;
        int n;
        n = $urandom_range(1, maxlen);
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(rand_name_char(i == 0))};
        return s;
    endfunction

    function automatic string rand_value();
        string s;
        string ents[6];
        int n;
        ents = '{"&lt;", "&gt;", "&amp;", "&apos;", "&quot;", "&ap;"};
        s = "";
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
            case ($urandom_range(0, 9))
                0: s = {s, ents[$urandom_range(0, 5)]};
                1: s = {s, " "};
                default: s = {s, string'(rand_name_char(0))};
            endcase
        return s;
    endfunction

    // Directed: tag name rules, pair rules, entities and capacity
    task automatic test_directed();
        send_tag("a");
        send_tag(" a");
        send_tag("\tb");
        send_tag("-x");
        send_tag("ab$c");
        send_tag("t x=\"1\"");
        send_tag("t x='a&lt;&gt;&amp;&apos;&quot;b' y=\"'\"");
        send_tag("t =\"1\"");
        send_tag("t 9a=\"1\"");
        send_tag("t a b=\"1\"");
        send_tag("t a= z\"1\"");
        send_tag("t a=\"<\"");
        send_tag("t a=\"&am\"");
        send_tag("t a=\"&x;\"");
        send_tag("t a=\"1\" a='2'");
        send_tag("t a=\"1");
        send_tag("t a=\"1\" b");
        send_tag("t a=\"1\"  ");
        send_tag("t a");
        send_tag("t aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa=\"1\"");
        send_tag("t aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa=\"1\"");
        send_tag("t a=\"\" b=\"\" c=\"\" d=\"\" e=\"\" f=\"\" g=\"\" h=\"\" i=\"\"");
        send_tag({"t a=\"", 8'hFF, 8'h80, "\" ", 8'hC3, "=\"\""});
        send_tag({8'hFF});
        send_tag({"x", 8'h00});
    endtask

    // Pause the sender until every queued result has come back
    task automatic test_drain();
        idle_sender();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Random: mostly well-formed tags with random content, some noise
    task automatic test_random(int n_bytes);
        int sent;
        string s;
        string sep;
        string nm;
        string eq;
        string q;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                int k;
                k = $urandom_range(1, 12);
                for (int i = 0; i < k; i++)
                    send_byte(8'($urandom_range(0, 255)), i == k - 1 || $urandom_range(0, 15) == 0);
                sent += k;
            end
            else
            begin
                s = rand_name(6);
                repeat ($urandom_range(0, 9))
                begin
                    if ($urandom_range(0, 1) != 0)
                        sep = " ";
                    else
                        sep = "\t";
                    if ($urandom_range(0, 7) == 0)
                        nm = "a";
                    else
                        nm = rand_name($urandom_range(0, 9) == 0 ? 34 : 3);
                    if ($urandom_range(0, 3) == 0)
                        eq = " = ";
                    else
                        eq = "=";
                    if ($urandom_range(0, 1) != 0)
                        q = "\"";
                    else
                        q = "'";
                    s = {s, sep, nm, eq, q};
                    s = {s, rand_value(), q};
                end
                if ($urandom_range(0, 7) == 0)
                    s = {s, " x"};
                send_tag(s);
                sent += s.len();
            end
            if ($urandom_range(0, 3) == 0)
            begin
                idle_sender();
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        tag_char = '0;
        last_char = 1'b0;
        mismatches = 0;
        cycles = 0;
        lost_results = 0;
        stall_on = 0;
        clear_parser();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_drain();
        test_random(1400);
        test_drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/xta_pkg.sv
rtl/xta_ram.sv
rtl/xta_front.sv
rtl/xta_back.sv
rtl/xml_tag_attribute_checker.sv
test/tb_top.sv
